// ----- rtl/cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared constants, widths and controller/datapath link types for the
// centered boxcar smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

   // line and window limits
   localparam int MAX_HALF_WIDTH = 31;
   localparam int LINE_PIXELS    = 4096;
   localparam int HALF_W_RESET   = 2;

   // field widths
   localparam int DATA_W = 16;
   localparam int HALF_W = 5;
   localparam int SUM_W  = 22;

   // derived widths
   localparam int ACT_W       = $clog2(MAX_HALF_WIDTH + 1);
   localparam int POS_W       = $clog2(LINE_PIXELS);
   localparam int CNT_W       = $clog2(2 * MAX_HALF_WIDTH + 2);
   localparam int STORE_AW    = $clog2(2 * MAX_HALF_WIDTH + 2);
   localparam int STORE_DEPTH = 1 << STORE_AW;
   localparam int ITER_W      = $clog2(SUM_W + 1);

   // controller to datapath commands
   typedef struct packed {
      logic accept;     // take the input item, write it to the ring
      logic update;     // fold new sample in, drop the expired one
      logic div_load;   // start a division of the window sum
      logic div_step;   // one restoring division step
      logic out_load;   // move the quotient into the output register
      logic rd_drop;    // address the ring at the sample leaving the window
      logic drop;       // subtract the sample leaving the window
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic more;       // results still pending for this item
      logic div_done;   // quotient ready
      logic out_free;   // output register can take a new result
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/cbs_if.sv -----
// ----------------------------------------------------------------------------
// cbs_if
// Valid/ready channels of the smoother: pixel input, result output and the
// half-width register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbs_req_if;
   logic                       valid;
   logic                       ready;
   logic [cbs_pkg::DATA_W-1:0] sample;
   logic                       line_end;

   modport source (output valid, output sample, output line_end, input ready);
   modport sink   (input valid, input sample, input line_end, output ready);
endinterface

interface cbs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [cbs_pkg::DATA_W-1:0] smoothed;
   logic                       line_done;

   modport source (output valid, output smoothed, output line_done, input ready);
   modport sink   (input valid, input smoothed, input line_done, output ready);
endinterface

interface cbs_csr_if;
   logic                       valid;
   logic                       ready;
   logic [cbs_pkg::HALF_W-1:0] half_width;

   modport source (output valid, output half_width, input ready);
   modport sink   (input valid, input half_width, output ready);
endinterface

`default_nettype wire

// ----- rtl/centered_boxcar_smoother_core.sv -----
// Flow: a pixel that completes a window yields one result; at a line end the
// further results are flushed one after another. A new pixel is taken only once
// the results due for the last one are out; each result is set by the 22-step
// restoring divider (one quotient bit a cycle), and output stalls hold the
// sequencer.
// Reset: synchronous, clears line state and output valid; half-width becomes 2.
// ----------------------------------------------------------------------------
// centered_boxcar_smoother_core
// Centered moving average over one line of pixels with a window clipped at
// both line ends; a running sum over a sample ring feeds a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module centered_boxcar_smoother_core (
   input wire logic clock,
   input wire logic reset,
   cbs_req_if.sink  req_chan,
   cbs_rsp_if.source rsp_chan,
   cbs_csr_if.sink  csr_chan
);

   cbs_pkg::cmd_type    cmd;
   cbs_pkg::status_type status;
   logic                req_ready;

   // sequencer
   cbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // ring, sum, divider and output register
   cbs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_chan.sample),
      .req_line_end   (req_chan.line_end),
      .csr_valid      (csr_chan.valid),
      .csr_half_width (csr_chan.half_width),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_smoothed   (rsp_chan.smoothed),
      .rsp_line_done  (rsp_chan.line_done)
   );

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

`ifndef SYNTHESIS
   // a transfer moves the sequencer out of idle, so input is not ready in the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("input ready right after a transfer");

   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result register overwritten");

   // a loaded result is presented in the next cycle
   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_chan.valid)
      else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/cbs_ram.sv -----
// ----------------------------------------------------------------------------
// cbs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/cbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// cbs_ctrl
// Sequencer of the smoother: accepts a pixel, updates the running window
// sum, then runs one division and one output transfer per pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire cbs_pkg::status_type status,
   output      cbs_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_UPDATE = 7'b0000010,
      ST_LOAD   = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_OUT    = 7'b0010000,
      ST_NEXT   = 7'b0100000,
      ST_DROP   = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.more ? ST_LOAD : ST_IDLE;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (status.more) begin
               cmd.rd_drop = 1'b1;
               state_in    = ST_DROP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DROP: begin
            cmd.drop = 1'b1;
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/cbs_datapath.sv -----
// ----------------------------------------------------------------------------
// cbs_datapath
// Sample ring, running window sum, line counters, restoring divider and the
// output register of the smoother.
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cbs_pkg::cmd_type           cmd,
   output      cbs_pkg::status_type        status,
   input  wire logic [cbs_pkg::DATA_W-1:0] req_sample,
   input  wire logic                       req_line_end,
   input  wire logic                       csr_valid,
   input  wire logic [cbs_pkg::HALF_W-1:0] csr_half_width,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      logic [cbs_pkg::DATA_W-1:0] rsp_smoothed,
   output      logic                       rsp_line_done
);

   localparam int POS_W = cbs_pkg::POS_W;
   localparam int ACT_W = cbs_pkg::ACT_W;
   localparam int CNT_W = cbs_pkg::CNT_W;
   localparam int SUM_W = cbs_pkg::SUM_W;
   localparam int AW    = cbs_pkg::STORE_AW;

   // configuration and line state
   logic [cbs_pkg::HALF_W-1:0] half_width_ff;
   logic [ACT_W-1:0]           active_half_ff;
   logic [POS_W-1:0]           pos_ff;
   logic [POS_W-1:0]           cur_r_ff;
   logic                       end_ff;
   // one bit wider so a full-length line can count past its last position
   logic [POS_W:0]             emit_ff;
   logic [cbs_pkg::DATA_W-1:0] sample_ff;
   logic [SUM_W-1:0]           sum_ff;

   // divider
   logic [CNT_W-1:0]           rem_ff;
   logic [SUM_W-1:0]           quo_ff;
   logic [CNT_W-1:0]           div_ff;
   logic [cbs_pkg::ITER_W-1:0] iter_ff;

   // output register
   logic                       rsp_valid_ff;
   logic [cbs_pkg::DATA_W-1:0] rsp_smoothed_ff;
   logic                       rsp_line_done_ff;

   logic [ACT_W-1:0]           half_sat;
   logic [ACT_W-1:0]           h_acc;
   logic                       line_end_acc;
   logic [POS_W:0]             old_idx_acc;
   logic [POS_W-1:0]           h_cur;
   logic [POS_W:0]             span_cur;
   logic                       old_valid;
   logic [POS_W-1:0]           lo;
   logic [POS_W-1:0]           cnt_full;
   logic [POS_W:0]             target;
   logic                       drop_valid;
   logic [POS_W-1:0]           drop_idx;
   logic [AW-1:0]              rd_addr;
   logic [cbs_pkg::DATA_W-1:0] rd_data;
   logic [SUM_W-1:0]           sum_base;
   logic [SUM_W-1:0]           sum_in;
   logic [CNT_W:0]             rem_sh;
   logic                       q_bit;
   logic [CNT_W-1:0]           rem_in;

   // half-width in use: latched at the first pixel of a line, saturated
   assign half_sat = (32'(half_width_ff) > cbs_pkg::MAX_HALF_WIDTH)
                   ? ACT_W'(cbs_pkg::MAX_HALF_WIDTH) : ACT_W'(half_width_ff);
   assign h_acc    = (pos_ff == '0) ? half_sat : active_half_ff;

   // line end, forced on an overlong line
   assign line_end_acc = req_line_end || (pos_ff == POS_W'(cbs_pkg::LINE_PIXELS - 1));

   // sample that leaves the window when a new one arrives: r - 2h - 1
   assign old_idx_acc = {1'b0, pos_ff} - (POS_W+1)'({h_acc, 1'b1});
   assign h_cur       = POS_W'(active_half_ff);
   assign span_cur    = (POS_W+1)'({active_half_ff, 1'b1});
   assign old_valid   = ({1'b0, cur_r_ff} >= span_cur);

   // clipped window of the result about to be computed
   assign lo       = (emit_ff >= {1'b0, h_cur}) ? POS_W'(emit_ff - {1'b0, h_cur}) : '0;
   assign cnt_full = cur_r_ff - lo + POS_W'(1);

   // results due after this item
   always_comb begin
      if (end_ff) begin
         target = {1'b0, cur_r_ff} + (POS_W+1)'(1);
      end else if (cur_r_ff >= h_cur) begin
         target = {1'b0, cur_r_ff - h_cur} + (POS_W+1)'(1);
      end else begin
         target = '0;
      end
   end

   // sample that leaves the window between two flushed results
   assign drop_valid = (emit_ff > {1'b0, h_cur});
   assign drop_idx   = POS_W'(emit_ff - (POS_W+1)'(1) - {1'b0, h_cur});

   // ring read address
   assign rd_addr = cmd.rd_drop ? drop_idx[AW-1:0] : old_idx_acc[AW-1:0];

   cbs_ram #(
      .WIDTH (cbs_pkg::DATA_W),
      .DEPTH (cbs_pkg::STORE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.accept),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // running window sum
   assign sum_base = (cur_r_ff == '0) ? '0 : sum_ff;
   always_comb begin
      sum_in = sum_ff;
      if (cmd.update) begin
         sum_in = sum_base + SUM_W'(sample_ff)
                - (old_valid ? SUM_W'(rd_data) : '0);
      end else if (cmd.drop) begin
         sum_in = sum_ff - (drop_valid ? SUM_W'(rd_data) : '0);
      end
   end

   // restoring division step
   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, div_ff});
   assign rem_in = q_bit ? CNT_W'(rem_sh - {1'b0, div_ff}) : CNT_W'(rem_sh);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff  <= cbs_pkg::HALF_W'(cbs_pkg::HALF_W_RESET);
         active_half_ff <= '0;
         pos_ff         <= '0;
         emit_ff        <= '0;
         sum_ff         <= '0;
         iter_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            half_width_ff <= csr_half_width;
         end
         if (cmd.accept) begin
            active_half_ff <= h_acc;
            pos_ff         <= line_end_acc ? '0 : pos_ff + POS_W'(1);
            if (pos_ff == '0) begin
               emit_ff <= '0;
            end
         end
         if (cmd.out_load) begin
            emit_ff <= emit_ff + (POS_W+1)'(1);
         end
         sum_ff <= sum_in;
         if (cmd.div_load) begin
            iter_ff <= cbs_pkg::ITER_W'(SUM_W);
         end else if (cmd.div_step) begin
            iter_ff <= iter_ff - cbs_pkg::ITER_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_r_ff  <= pos_ff;
         end_ff    <= line_end_acc;
         sample_ff <= req_sample;
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= sum_ff;
         div_ff <= CNT_W'(cnt_full);
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[SUM_W-2:0], q_bit};
      end
      if (cmd.out_load) begin
         rsp_smoothed_ff  <= quo_ff[cbs_pkg::DATA_W-1:0];
         rsp_line_done_ff <= end_ff && (emit_ff == {1'b0, cur_r_ff});
      end
   end

   assign status.more     = (emit_ff < target);
   assign status.div_done = (iter_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_smoothed  = rsp_smoothed_ff;
   assign rsp_line_done = rsp_line_done_ff;

endmodule

`default_nettype wire
